### hdl/sem_pkg.sv
// ---------------------------------------------------------------------------
// sem_pkg: shared definitions for the Sobel edge magnitude core
// Constants, controller state type, command and status structs, and the
// per-channel Sobel gradient function.
// ---------------------------------------------------------------------------
package sem_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int DimW      = 11;
	localparam int PixW      = 24;
	localparam int ChanW     = 8;
	localparam int GradW     = 12;
	localparam int SumW      = 21;
	localparam int IdxW      = 2;

	localparam logic [DimW-1:0] WidthMax  = DimW'(MaxWidth);
	localparam logic [DimW-1:0] HeightMax = DimW'(MaxHeight);
	localparam logic [ChanW-1:0] SatLimit = 8'd255;
	localparam logic [SumW-1:0] SatSum    = SumW'(255 * 255 + 255 + 1);

	// Configuration register indexes.
	localparam logic [IdxW-1:0] RegFrameWidth  = 2'd0;
	localparam logic [IdxW-1:0] RegFrameHeight = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MAG,
		ST_SQ,
		ST_ROOT,
		ST_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       shift;
		logic       mag;
		logic       square;
		logic       root;
		logic [2:0] root_bit;
		logic       finish;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic drop;
		logic emit;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic signed [GradW-1:0] gx;
		logic signed [GradW-1:0] gy;
	} grad_t;

	// Sobel gradients of one channel with zero padding outside the frame.
	// Column 2 is the newest column, row 2 the newest row.
	function automatic grad_t sobel_grad(input logic [2:0][2:0][ChanW-1:0] p,
		input logic top, input logic bottom, input logic left, input logic right);
		grad_t g;
		logic signed [GradW-1:0] v;
		logic signed [GradW-1:0] wr;
		logic signed [GradW-1:0] wc;
		g.gx = '0;
		g.gy = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				v  = $signed({{(GradW-ChanW){1'b0}}, p[r][c]});
				wr = (r == 1) ? (v <<< 1) : v;
				wc = (c == 1) ? (v <<< 1) : v;
				if (!((r == 0 && top) || (r == 2 && bottom) ||
				      (c == 0 && left) || (c == 2 && right))) begin
					if (c == 0) g.gx = g.gx - wr;
					if (c == 2) g.gx = g.gx + wr;
					if (r == 0) g.gy = g.gy - wc;
					if (r == 2) g.gy = g.gy + wc;
				end
			end
		end
		return g;
	endfunction

endpackage

### hdl/sem_ctrl.sv
// ---------------------------------------------------------------------------
// sem_ctrl: sequencer of the Sobel edge magnitude core
// Steps one word through fetch and window shift and, if it yields a result,
// gradient, square, an eight-step square root and the final rounding.
// ---------------------------------------------------------------------------
module sem_ctrl import sem_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t     state_q, state_d;
	logic [2:0] bit_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && !stat.drop) state_d = ST_SHIFT;
			ST_SHIFT: state_d = stat.emit ? ST_MAG : ST_IDLE;
			ST_MAG:   state_d = ST_SQ;
			ST_SQ:    state_d = ST_ROOT;
			ST_ROOT:  if (bit_q == 3'd0) state_d = ST_FIN;
			ST_FIN:   if (stat.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		ctrl          = '0;
		ctrl.root_bit = bit_q;
		in_stall      = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:  ctrl.load   = in_valid && !stat.drop;
			ST_SHIFT: ctrl.shift  = 1'b1;
			ST_MAG:   ctrl.mag    = 1'b1;
			ST_SQ:    ctrl.square = 1'b1;
			ST_ROOT:  ctrl.root   = 1'b1;
			ST_FIN:   ctrl.finish = stat.out_free;
			default:  ctrl        = '0;
		endcase
	end

	// State register and root bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQ) bit_q <= 3'd7;
			else if (state_q == ST_ROOT) bit_q <= bit_q - 3'd1;
		end
	end

endmodule

### hdl/sem_datapath.sv
// ---------------------------------------------------------------------------
// sem_datapath: line store, window, arithmetic and output register
// Holds the frame counters, the combined two-line store, the 3x3 window,
// the gradient and root registers, and the result register.
// ---------------------------------------------------------------------------
module sem_datapath import sem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [DimW-1:0]  cfg_wdata,
	input  logic             cmd,
	input  logic [ChanW-1:0] red,
	input  logic [ChanW-1:0] green,
	input  logic [ChanW-1:0] blue,
	input  ctrl_t            ctrl,
	output stat_t            stat,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ChanW-1:0] edge_red,
	output logic [ChanW-1:0] edge_green,
	output logic [ChanW-1:0] edge_blue,
	output logic             last_of_frame
);

	logic [DimW-1:0] fw_q, fh_q;
	logic [DimW-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic [DimW-1:0] in_col_inc, in_row_inc, out_col_inc, out_row_inc;
	logic            draining_q;
	logic [PixW-1:0] pix_q;
	logic [2*PixW-1:0] line_mem [MaxWidth];
	logic [2*PixW-1:0] rd_q;
	logic [ColW-1:0]   col;
	logic [PixW-1:0]   win_q [3][3];
	logic top_q, bottom_q, left_q, right_q, last_q;
	logic signed [GradW-1:0] gx_q [3];
	logic signed [GradW-1:0] gy_q [3];
	logic [SumW-1:0]  sum_q  [3];
	logic [ChanW-1:0] root_q [3];
	logic [ChanW-1:0] res    [3];
	logic [ChanW-1:0] trial  [3];
	logic             restart;
	logic             out_valid_q;
	logic [DimW-1:0]  cfg_clamp;
	logic [DimW-1:0]  cfg_max;

	assign col         = in_col_q[ColW-1:0];
	assign in_col_inc  = in_col_q + 1'b1;
	assign in_row_inc  = in_row_q + 1'b1;
	assign out_col_inc = out_col_q + 1'b1;
	assign out_row_inc = out_row_q + 1'b1;

	// Status toward the controller.
	assign stat.drop     = !draining_q && cmd;
	assign stat.emit     = (in_row_q >= 11'd2) || (in_row_q == 11'd1 && in_col_q >= 11'd1);
	assign stat.out_free = !out_valid_q || !out_stall;

	// Width and height writes clamp to the legal range and restart the frame.
	assign cfg_max   = (cfg_index == RegFrameWidth) ? WidthMax : HeightMax;
	assign cfg_clamp = (cfg_wdata == '0) ? 11'd1 :
	                   (cfg_wdata > cfg_max) ? cfg_max : cfg_wdata;
	assign restart   = (cfg_we && (cfg_index == RegFrameWidth ||
	                   cfg_index == RegFrameHeight)) || (ctrl.mag && last_q);

	// Combined upper and middle line store, registered read.
	always_ff @(posedge clk) begin
		if (ctrl.load) rd_q <= line_mem[col];
		if (ctrl.shift) line_mem[col] <= {rd_q[PixW-1:0], pix_q};
	end

	// Pixel latch; pixels during the flush count as zero.
	always_ff @(posedge clk) begin
		if (ctrl.load) pix_q <= draining_q ? '0 : {red, green, blue};
	end

	// Frame size, counters, flush flag and window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= WidthMax;
			fh_q       <= HeightMax;
			in_row_q   <= '0;
			in_col_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			draining_q <= 1'b0;
			top_q      <= 1'b0;
			bottom_q   <= 1'b0;
			left_q     <= 1'b0;
			right_q    <= 1'b0;
			last_q     <= 1'b0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
		end else begin
			if (cfg_we && cfg_index == RegFrameWidth) fw_q <= cfg_clamp;
			if (cfg_we && cfg_index == RegFrameHeight) fh_q <= cfg_clamp;
			if (restart) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				draining_q <= 1'b0;
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
			end else if (ctrl.shift) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= rd_q[2*PixW-1:PixW];
				win_q[1][2] <= rd_q[PixW-1:0];
				win_q[2][2] <= pix_q;
				if (in_col_inc >= fw_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_inc;
					if (in_row_inc >= fh_q) draining_q <= 1'b1;
				end else begin
					in_col_q <= in_col_inc;
					if (in_row_q >= fh_q) draining_q <= 1'b1;
				end
				top_q    <= (out_row_q == '0);
				bottom_q <= (out_row_inc >= fh_q);
				left_q   <= (out_col_q == '0);
				right_q  <= (out_col_inc >= fw_q);
				last_q   <= (out_row_inc >= fh_q) && (out_col_inc >= fw_q);
			end else if (ctrl.mag) begin
				if (out_col_inc >= fw_q) begin
					out_col_q <= '0;
					out_row_q <= out_row_inc;
				end else begin
					out_col_q <= out_col_inc;
				end
			end
		end
	end

	// Gradients, sums of squares and the bit-by-bit root, one per channel.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial[ch] = root_q[ch] | (8'd1 << ctrl.root_bit);
			if (sum_q[ch] >= SatSum)
				res[ch] = SatLimit;
			else if (sum_q[ch] > SumW'({8'd0, root_q[ch]} * {8'd0, root_q[ch]})
			                     + SumW'(root_q[ch]))
				res[ch] = root_q[ch] + 8'd1;
			else
				res[ch] = root_q[ch];
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [2:0][2:0][ChanW-1:0] p;
			grad_t g;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					p[r][c] = win_q[r][c][(2-ch)*ChanW +: ChanW];
			g = sobel_grad(p, top_q, bottom_q, left_q, right_q);
			if (ctrl.mag) begin
				gx_q[ch] <= g.gx;
				gy_q[ch] <= g.gy;
			end
			if (ctrl.square) begin
				sum_q[ch]  <= SumW'(gx_q[ch]) * SumW'(gx_q[ch]) +
				              SumW'(gy_q[ch]) * SumW'(gy_q[ch]);
				root_q[ch] <= '0;
			end
			if (ctrl.root &&
			    SumW'({8'd0, trial[ch]} * {8'd0, trial[ch]}) <= sum_q[ch])
				root_q[ch] <= trial[ch];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			edge_red      <= res[0];
			edge_green    <= res[1];
			edge_blue     <= res[2];
			last_of_frame <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/sobel_edge_magnitude_rgb_core.sv
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core: 3x3 Sobel edge magnitude on RGB pixels
// Pixels enter in raster order on the input channel (valid/stall). Each
// accepted word with data produces, one row plus one pixel later, one
// output word with the saturated rounded gradient magnitude per channel.
// After the last pixel, frame_width+1 drain words (cmd=1) flush the rest;
// last_of_frame marks the final result. A drain word outside the flush is
// consumed without being fetched and gives nothing.
// A word that yields no result passes fetch and shift only; one that yields a
// result also passes gradient, square, eight root steps of the bit-serial
// square root and rounding. One word is worked on at a time.
// The output register holds a finished word; the core accepts the next
// input while it waits, and only the final rounding step waits on stall.
// Reset sets the frame to 1024x1024 and clears counters and window; the
// line store is not cleared. Writes to frame_width (0) and frame_height
// (1) restart the frame; the user makes them only while idle (unchecked).
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core import sem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [DimW-1:0]  cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cmd,
	input  logic [ChanW-1:0] red,
	input  logic [ChanW-1:0] green,
	input  logic [ChanW-1:0] blue,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ChanW-1:0] edge_red,
	output logic [ChanW-1:0] edge_green,
	output logic [ChanW-1:0] edge_blue,
	output logic             last_of_frame
);

	ctrl_t ctrl;
	stat_t stat;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	sem_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.ctrl          (ctrl),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.edge_red      (edge_red),
		.edge_green    (edge_green),
		.edge_blue     (edge_blue),
		.last_of_frame (last_of_frame)
	);

endmodule

### verif/sem_checker.sv
// ---------------------------------------------------------------------------
// sem_checker: scoreboard for the Sobel edge magnitude core
// Watches the configuration port and both word channels, keeps its own model
// of the line stores, the 3x3 window and the frame counters, works out the
// expected edge word for each accepted input word that yields one, and
// compares it, field by field, with each accepted output word.
// ---------------------------------------------------------------------------
module sem_checker import sem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [DimW-1:0]  cfg_wdata,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             cmd,
	input  logic [ChanW-1:0] red,
	input  logic [ChanW-1:0] green,
	input  logic [ChanW-1:0] blue,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [ChanW-1:0] edge_red,
	input  logic [ChanW-1:0] edge_green,
	input  logic [ChanW-1:0] edge_blue,
	input  logic             last_of_frame,
	output int               fails,
	output int               pending,
	output int               seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
		logic             last;
	} edge_word_t;

	edge_word_t       edge_q[$];
	logic [PixW-1:0]  upper_store[MaxWidth];
	logic [PixW-1:0]  middle_store[MaxWidth];
	logic [PixW-1:0]  wnd[3][3];
	logic [DimW-1:0]  fw, fh;
	int unsigned      in_r, in_c, out_r, out_c;
	bit               flushing;

	// Clamp a written register value into its legal range.
	function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] top);
		if (v == 0) return DimW'(1);
		if (v > top) return top;
		return v;
	endfunction

	// Rounded square root, saturated at the channel maximum.
	function automatic logic [ChanW-1:0] round_sqrt(int unsigned s);
		int unsigned n;
		int unsigned t;
		n = 0;
		if (s >= 65281) return SatLimit;
		for (int k = 7; k >= 0; k--) begin
			t = n | (1 << k);
			if (t * t <= s) n = t;
		end
		if (s > n * n + n) n++;
		return (n > 255) ? SatLimit : ChanW'(n);
	endfunction

	// Gradient magnitude of one channel with zero padding at the borders.
	function automatic logic [ChanW-1:0] chan_mag(int sh, bit t, bit bt, bit l, bit rt);
		int gx, gy, v;
		gx = 0;
		gy = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if ((r == 0 && t) || (r == 2 && bt) || (c == 0 && l) || (c == 2 && rt))
					continue;
				v = int'((wnd[r][c] >> sh) & 24'hff);
				gx += v * (c - 1) * ((r == 1) ? 2 : 1);
				gy += v * (r - 1) * ((c == 1) ? 2 : 1);
			end
		end
		return round_sqrt(gx * gx + gy * gy);
	endfunction

	task automatic restart();
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				wnd[r][c] = '0;
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
		flushing = 0;
	endtask

	// Advance the model by one accepted input word.
	task automatic take_word(logic c_in, logic [PixW-1:0] px_in);
		logic [PixW-1:0] px;
		int unsigned     col;
		bit              emit, t, bt, l, rt;
		edge_word_t      ew;
		if (!flushing && c_in) return;
		px = flushing ? '0 : px_in;
		col = (in_c < MaxWidth) ? in_c : 0;
		for (int r = 0; r < 3; r++) begin
			wnd[r][0] = wnd[r][1];
			wnd[r][1] = wnd[r][2];
		end
		wnd[0][2] = upper_store[col];
		wnd[1][2] = middle_store[col];
		wnd[2][2] = px;
		upper_store[col] = middle_store[col];
		middle_store[col] = px;
		emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
		in_c++;
		if (in_c >= fw) begin
			in_c = 0;
			in_r++;
		end
		if (in_r >= fh) flushing = 1;
		if (!emit) return;
		t = (out_r == 0);
		bt = (out_r + 1 >= fh);
		l = (out_c == 0);
		rt = (out_c + 1 >= fw);
		ew.r = chan_mag(16, t, bt, l, rt);
		ew.g = chan_mag(8, t, bt, l, rt);
		ew.b = chan_mag(0, t, bt, l, rt);
		ew.last = bt && rt;
		edge_q.push_back(ew);
		if (ew.last) begin
			restart();
		end else begin
			out_c++;
			if (out_c >= fw) begin
				out_c = 0;
				out_r++;
			end
		end
	endtask

	task automatic cmp8(string nm, logic [ChanW-1:0] e, logic [ChanW-1:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
			fails++;
		end
	endtask

	// Model update and comparison on every clock edge.
	always @(posedge clk or negedge arst_n) begin
		edge_word_t ew;
		if (!arst_n) begin
			for (int i = 0; i < MaxWidth; i++) begin
				upper_store[i] = '0;
				middle_store[i] = '0;
			end
			fw = WidthMax;
			fh = HeightMax;
			restart();
			edge_q.delete();
			fails = 0;
			seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegFrameWidth) begin
					fw = clamp_dim(cfg_wdata, WidthMax);
					restart();
				end else if (cfg_index == RegFrameHeight) begin
					fh = clamp_dim(cfg_wdata, HeightMax);
					restart();
				end
			end
			if (in_valid && !in_stall)
				take_word(cmd, {red, green, blue});
			if (out_valid && !out_stall) begin
				seen++;
				if (edge_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %0d/%0d/%0d last=%0b",
						$time, edge_red, edge_green, edge_blue, last_of_frame);
					fails++;
				end else begin
					ew = edge_q.pop_front();
					cmp8("edge_red", ew.r, edge_red);
					cmp8("edge_green", ew.g, edge_green);
					cmp8("edge_blue", ew.b, edge_blue);
					if (ew.last !== last_of_frame) begin
						$display("%0t: last_of_frame mismatch, expected %0b, actual %0b",
							$time, ew.last, last_of_frame);
						fails++;
					end
				end
			end
		end
		pending = edge_q.size();
	end

endmodule

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb: top-level testbench for the Sobel edge magnitude core
// Drives frames of RGB words with random idling on both channels, register
// writes between frames (including clamped and unknown ones), an abandoned
// frame, stray drain words and a long output hold-off. The checker module
// predicts and compares; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb import sem_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IdxW-1:0]  cfg_index;
	logic [DimW-1:0]  cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic             cmd;
	logic [ChanW-1:0] red, green, blue;
	logic             out_valid;
	logic             out_stall;
	logic [ChanW-1:0] edge_red, edge_green, edge_blue;
	logic             last_of_frame;
	int               fails, pending, seen;

	bit  calm;
	int  word_cnt;
	int  frame_cnt;
	int  quiet_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	sobel_edge_magnitude_rgb_core u_top (.*);

	sem_checker u_chk (.*);

	// Output side: random stall, one long hold-off once results flow.
	initial begin
		int  hold_n;
		bit  held;
		hold_n = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && seen >= 150) begin
				held = 1'b1;
				hold_n = 400;
			end
			if (hold_n > 0) begin
				hold_n--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 22);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 3000) begin
				$display("%0t: watchdog timeout", $time);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic [ChanW-1:0] pick8();
		int k;
		k = $urandom_range(3);
		if (k == 0) return 8'd0;
		if (k == 1) return 8'd255;
		return ChanW'($urandom);
	endfunction

	// Offer one word and hold it until accepted; called at a clock edge.
	task automatic put_word(logic c, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and let every expected word come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic [IdxW-1:0] idx, logic [DimW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One well-formed frame with random content and optional noise words.
	task automatic run_frame(int w, int h, bit noisy);
		for (int i = 0; i < w * h; i++) begin
			if (noisy && $urandom_range(99) < 4) begin
				put_word(1'b1, ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
				word_cnt++;
			end
			put_word(1'b0, pick8(), pick8(), pick8());
			word_cnt++;
		end
		for (int i = 0; i <= w; i++) begin
			if (noisy && $urandom_range(99) < 25)
				put_word(1'b0, ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
			else
				put_word(1'b1, 8'd0, 8'd0, 8'd0);
			word_cnt++;
		end
		frame_cnt++;
	endtask

	task automatic set_frame(logic [DimW-1:0] w, logic [DimW-1:0] h);
		settle();
		reg_write(RegFrameWidth, w);
		reg_write(RegFrameHeight, h);
	endtask

	// Stimulus and verdict.
	initial begin
		int w, h;
		calm = 1'b0;
		word_cnt = 0;
		frame_cnt = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 3x3 frame with a saturating checkerboard,
		// a stray drain word first and a pixel word during the flush.
		set_frame(11'd3, 11'd3);
		put_word(1'b1, 8'd255, 8'd255, 8'd255);
		for (int i = 0; i < 9; i++) begin
			if (i % 2 == 0) put_word(1'b0, 8'd255, 8'd0, 8'd255);
			else put_word(1'b0, 8'd0, 8'd255, 8'd1);
		end
		put_word(1'b0, 8'd255, 8'd255, 8'd255);
		repeat (3) put_word(1'b1, 8'd0, 8'd0, 8'd0);
		word_cnt += 14;
		frame_cnt++;

		// Smallest frame, then unknown register indexes.
		set_frame(11'd1, 11'd1);
		run_frame(1, 1, 1'b0);
		settle();
		reg_write(2'd2, 11'h7ff);
		reg_write(2'd3, 11'h000);
		run_frame(1, 1, 1'b0);

		// Abandoned frame: a register write restarts it.
		set_frame(11'd5, 11'd4);
		for (int i = 0; i < 7; i++) put_word(1'b0, pick8(), pick8(), pick8());
		word_cnt += 7;

		// Clamped values: width 0 reads as 1, height 2047 as the maximum.
		set_frame(11'd0, 11'h7ff);
		run_frame(1, 1024, 1'b1);

		// Random frames, mostly small, with one stretch without idling.
		set_frame(11'd4, 11'd3);
		w = 4;
		h = 3;
		while (word_cnt < 1350) begin
			if ($urandom_range(2) == 0) begin
				if ($urandom_range(9) == 0) begin
					w = $urandom_range(9, 40);
				end else begin
					w = $urandom_range(1, 8);
				end
				h = $urandom_range(1, 6);
				set_frame(DimW'(w), DimW'(h));
			end
			calm = (word_cnt >= 1150 && word_cnt < 1250);
			run_frame(w, h, 1'b1);
		end
		calm = 1'b0;
		settle();

		$display("Ran %0d frames, %0d input words and %0d edge words, with clamped,",
			frame_cnt, word_cnt, seen);
		$display("unknown and restarting register writes and a long output hold-off.");
		if (fails == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d edge words never arrived", fails, pending);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### sim.f
hdl/sem_pkg.sv
hdl/sem_ctrl.sv
hdl/sem_datapath.sv
hdl/sobel_edge_magnitude_rgb_core.sv
verif/sem_checker.sv
verif/tb.sv
